>>> src/lkvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // APB register map: one 32-bit register per word.
    localparam int APB_DW    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0]     CAP_RESET    = CAP_W'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    typedef logic [MAX_ENTRIES-1:0][IDX_W-1:0] t_rank_arr;

    // Update request from the controller to the recency table.
    typedef struct packed {
        logic             promote;
        logic             insert;
        logic             evict;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] victim_idx;
    } t_rec_cmd;

endpackage

`default_nettype wire

>>> src/lkvc_kv_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_kv_mem
// Key and value storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lkvc_kv_mem (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [lkvc_pkg::IDX_W-1:0]              i_waddr,
    input  wire logic [lkvc_pkg::KEY_W+lkvc_pkg::VAL_W-1:0] i_wdata,
    input  wire logic [lkvc_pkg::IDX_W-1:0]              i_raddr,
    output logic [lkvc_pkg::KEY_W+lkvc_pkg::VAL_W-1:0]   o_rdata
);
    import lkvc_pkg::*;

    logic [KEY_W+VAL_W-1:0] r_mem [MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/lkvc_recency.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_recency
// Valid bits, recency ranks and fill count, registered and updated from each request command.
// ----------------------------------------------------------------------------
module lkvc_recency (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire lkvc_pkg::t_rec_cmd              i_cmd,
    output logic [lkvc_pkg::MAX_ENTRIES-1:0]     o_valid,
    output lkvc_pkg::t_rank_arr                  o_rank,
    output logic [lkvc_pkg::CNT_W-1:0]           o_occupied,
    output logic [lkvc_pkg::IDX_W-1:0]           o_free_idx
);
    import lkvc_pkg::*;

    logic [MAX_ENTRIES-1:0] r_valid, n_valid;
    t_rank_arr              r_rank, n_rank;
    logic [CNT_W-1:0]       r_occ, n_occ;
    logic [MAX_ENTRIES-1:0] kept;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       hit_rank;

    always_comb begin
        kept = r_valid;
        if (i_cmd.evict) begin
            kept[i_cmd.victim_idx] = 1'b0;
        end

        // Lowest-numbered free slot once the victim is gone.
        free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!kept[i]) begin
                free_idx = IDX_W'(i);
            end
        end

        hit_rank = r_rank[i_cmd.hit_idx];
        n_valid  = r_valid;
        n_rank   = r_rank;
        n_occ    = r_occ;

        if (i_cmd.promote) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
            end
            n_rank[i_cmd.hit_idx] = '0;
        end else if (i_cmd.insert) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (kept[i]) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
            end
            if (i_cmd.evict) begin
                n_rank[i_cmd.victim_idx] = '0;
            end
            n_rank[free_idx]  = '0;
            n_valid           = kept;
            n_valid[free_idx] = 1'b1;
            n_occ             = i_cmd.evict ? r_occ : r_occ + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rank  <= '0;
            r_occ   <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
            r_occ   <= n_occ;
        end
    end

    assign o_valid    = r_valid;
    assign o_rank     = r_rank;
    assign o_occupied = r_occ;
    assign o_free_idx = free_idx;

endmodule

`default_nettype wire

>>> src/lkvc_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_apb_regs
// APB register bank holding the capacity setting.
// ----------------------------------------------------------------------------
module lkvc_apb_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lkvc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lkvc_pkg::APB_DW-1:0]   pwdata,
    output logic [lkvc_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    output logic [lkvc_pkg::CAP_W-1:0]         o_capacity
);
    import lkvc_pkg::*;

    logic [CAP_W-1:0]     r_capacity;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (wr_en && (reg_idx == REG_CAPACITY)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_CAPACITY) begin
            prdata = APB_DW'(r_capacity);
        end
    end

    assign o_capacity = r_capacity;

endmodule

`default_nettype wire

>>> src/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request reads every entry through the single read port of the key/value memory,
// checks the registered read data, then passes a finish state; the result strobe is
// registered from the finish state. Busy stays high from the search until idle.
// The result cannot be stalled; a new request is taken while it is shown.
// Reset clears valid bits, ranks, fill count and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lkvc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lkvc_pkg::APB_DW-1:0]   pwdata,
    output logic [lkvc_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cmd,
    input  wire logic signed [31:0]            i_lookup_key,
    input  wire logic signed [31:0]            i_write_value,
    output logic                               o_valid,
    output logic                               o_hit,
    output logic signed [31:0]                 o_read_value,
    output logic                               o_evicted,
    output logic signed [31:0]                 o_evicted_key
);
    import lkvc_pkg::*;

    t_state r_state, n_state;

    logic [CAP_W-1:0]       capacity;
    logic [CMP_W-1:0]       eff_cap;
    logic [CMP_W-1:0]       occ_ext;

    logic                   r_cmd;
    logic [KEY_W-1:0]       r_key;
    logic [VAL_W-1:0]       r_val;
    logic [IDX_W:0]         r_cnt;
    logic [IDX_W-1:0]       r_rd_idx;
    logic                   r_rd_live;
    logic                   r_hit;
    logic [IDX_W-1:0]       r_hit_idx;
    logic [VAL_W-1:0]       r_hit_val;
    logic [IDX_W-1:0]       r_vic_idx;
    logic [KEY_W-1:0]       r_vic_key;

    logic [KEY_W+VAL_W-1:0] rd_data;
    logic [KEY_W-1:0]       rd_key;
    logic [VAL_W-1:0]       rd_val;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;

    logic [MAX_ENTRIES-1:0] valid;
    t_rank_arr              rank;
    logic [CNT_W-1:0]       occupied;
    logic [IDX_W-1:0]       free_idx;
    t_rec_cmd               rec_cmd;

    logic                   accept;
    logic                   fin;
    logic                   do_evict;
    logic                   do_insert;
    logic                   entry_live;

    lkvc_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    lkvc_kv_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata ({r_key, r_val}),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    lkvc_recency u_rec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (rec_cmd),
        .o_valid    (valid),
        .o_rank     (rank),
        .o_occupied (occupied),
        .o_free_idx (free_idx)
    );

    assign rd_key = rd_data[KEY_W+VAL_W-1:VAL_W];
    assign rd_val = rd_data[VAL_W-1:0];

    // A capacity of zero behaves as one; anything above the table size is clipped.
    always_comb begin
        eff_cap = CMP_W'(capacity);
        if (capacity == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end
    end
    assign occ_ext = CMP_W'(occupied);

    assign accept     = start && !busy;
    assign fin        = (r_state == ST_FINISH);
    assign do_insert  = fin && (r_cmd == CMD_PUT) && !r_hit;
    assign do_evict   = do_insert && (occupied != '0) && (occ_ext >= eff_cap);
    assign entry_live = r_rd_live && valid[r_rd_idx];

    always_comb begin
        rec_cmd.promote    = fin && r_hit;
        rec_cmd.insert     = do_insert;
        rec_cmd.evict      = do_evict;
        rec_cmd.hit_idx    = r_hit_idx;
        rec_cmd.victim_idx = r_vic_idx;
    end

    assign mem_we    = (fin && r_hit && (r_cmd == CMD_PUT)) || do_insert;
    assign mem_waddr = r_hit ? r_hit_idx : free_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // The read of the last entry returns while the counter sits at the end.
                if (r_cnt[IDX_W]) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_rd_live <= 1'b0;
            r_hit     <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_rd_live <= (r_state == ST_SEARCH) && !r_cnt[IDX_W];
            o_valid   <= fin;
            if (accept) begin
                r_cnt <= '0;
                r_hit <= 1'b0;
            end else if ((r_state == ST_SEARCH) && !r_cnt[IDX_W]) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (entry_live && (rd_key == r_key) && !r_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt[IDX_W-1:0];
        if (accept) begin
            r_cmd <= i_cmd;
            r_key <= i_lookup_key;
            r_val <= i_write_value;
        end
        if (entry_live && (rd_key == r_key) && !r_hit) begin
            r_hit_idx <= r_rd_idx;
            r_hit_val <= rd_val;
        end
        // Ranks are unique among valid entries, so the oldest one has rank fill-1.
        if (entry_live && ({1'b0, rank[r_rd_idx]} == CNT_W'(occupied - 1'b1))) begin
            r_vic_idx <= r_rd_idx;
            r_vic_key <= rd_key;
        end
        if (fin) begin
            o_hit         <= r_hit;
            o_read_value  <= (r_hit && (r_cmd == CMD_GET)) ? r_hit_val : '1;
            o_evicted     <= do_evict;
            o_evicted_key <= do_evict ? r_vic_key : '0;
        end
    end

    a_fill_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid) == int'(occupied))
        else $error("fill count disagrees with valid bits");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(occupied) <= MAX_ENTRIES)
        else $error("fill count above table size");

    a_strobe_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_FINISH))
        else $error("result strobe without a finished request");

    a_evict_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evicted) |-> !o_hit)
        else $error("eviction reported on a hit");

endmodule

`default_nettype wire

>>> test/tb_lru_key_value_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_top
// Drives get and put requests into the LRU key-value cache and checks every
// result against a cycle-free model of the store and its recency order. The
// capacity register is changed between bursts of traffic, including a drop
// below the current fill, and read back over the register port.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_top;
    import lkvc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 25;
    localparam int POOL_SIZE      = 32;
    localparam int PHASE_ITEMS    = 193;
    localparam int MAX_PRINTS     = 100;
    localparam logic [REG_IDX_W-1:0] SPARE_REG = REG_IDX_W'(1);

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_cache_req;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } t_cache_resp;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     psel          = 1'b0;
    logic                     penable       = 1'b0;
    logic                     pwrite        = 1'b0;
    logic [ADDR_W-1:0]        paddr         = '0;
    logic [APB_DW-1:0]        pwdata        = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;
    logic                     start         = 1'b0;
    logic                     busy;
    logic                     i_cmd         = CMD_GET;
    logic signed [31:0]       i_lookup_key  = '0;
    logic signed [31:0]       i_write_value = '0;
    logic                     o_valid;
    logic                     o_hit;
    logic signed [31:0]       o_read_value;
    logic                     o_evicted;
    logic signed [31:0]       o_evicted_key;

    lru_key_value_cache_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    always #6 i_clk = ~i_clk;

    t_cache_req         pending_reqs[$];
    t_cache_resp        expected_responses[$];
    t_cache_req         cur_req = '0;
    logic signed [31:0] key_pool[POOL_SIZE];
    int                 issued_count   = 0;
    int                 accepted_count = 0;
    int                 resp_seen      = 0;
    int                 fail_count     = 0;
    int                 idle_left      = 0;
    int                 idle_cycles    = 0;
    bit                 idling_on      = 1'b1;
    bit                 run_done       = 1'b0;

    // Shadow copy of the cache contents and recency order.
    logic [KEY_W-1:0]   mdl_key[MAX_ENTRIES];
    logic [VAL_W-1:0]   mdl_value[MAX_ENTRIES];
    bit                 mdl_valid[MAX_ENTRIES];
    int                 mdl_rank[MAX_ENTRIES];
    int                 mdl_fill;
    int                 mdl_capacity;

    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        if (fail_count < MAX_PRINTS)
            $display("MISMATCH result %0d %s: got %h, expected %h",
                     resp_seen, what, got, want);
        fail_count++;
    endtask

    function automatic t_cache_resp predict_cache_access(input t_cache_req req);
        t_cache_resp resp;
        int          found;
        int          victim;
        int          free_slot;
        int          limit;
        int          old_rank;
        resp.hit         = 1'b0;
        resp.read_value  = '1;
        resp.evicted     = 1'b0;
        resp.evicted_key = '0;
        found     = -1;
        victim    = -1;
        free_slot = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (found < 0 && mdl_valid[i] && mdl_key[i] == req.key)
                found = i;
        if (found >= 0) begin
            resp.hit = 1'b1;
            if (req.cmd == CMD_GET)
                resp.read_value = mdl_value[found];
            else
                mdl_value[found] = req.value;
            // Entries more recent than the hit one age by one step.
            old_rank = mdl_rank[found];
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (mdl_valid[i] && mdl_rank[i] < old_rank)
                    mdl_rank[i]++;
            mdl_rank[found] = 0;
        end else if (req.cmd == CMD_PUT) begin
            limit = (mdl_capacity == 0) ? 1 :
                    (mdl_capacity > MAX_ENTRIES) ? MAX_ENTRIES : mdl_capacity;
            // Only one entry goes even when the fill is above a lowered capacity.
            if (mdl_fill >= limit && mdl_fill > 0) begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (mdl_valid[i] && (victim < 0 || mdl_rank[i] > mdl_rank[victim]))
                        victim = i;
                if (victim >= 0) begin
                    resp.evicted     = 1'b1;
                    resp.evicted_key = mdl_key[victim];
                    mdl_valid[victim] = 1'b0;
                    mdl_rank[victim]  = 0;
                    mdl_fill--;
                end
            end
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (free_slot < 0 && !mdl_valid[i])
                    free_slot = i;
            if (free_slot >= 0) begin
                for (int j = 0; j < MAX_ENTRIES; j++)
                    if (mdl_valid[j])
                        mdl_rank[j]++;
                mdl_key[free_slot]   = req.key;
                mdl_value[free_slot] = req.value;
                mdl_valid[free_slot] = 1'b1;
                mdl_rank[free_slot]  = 0;
                mdl_fill++;
            end
        end
        return resp;
    endfunction

    // Request driver: holds start until the block takes the request.
    always @(posedge i_clk) begin : request_driver
        t_cache_req nxt_req;
        logic       nxt_start;
        nxt_req   = cur_req;
        nxt_start = start;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else begin
            if (start && !busy) begin
                expected_responses = {expected_responses, predict_cache_access(cur_req)};
                accepted_count++;
                nxt_start = 1'b0;
                if (idling_on && $urandom_range(0, 3) == 0)
                    idle_left = $urandom_range(1, 3);
            end else if (!start && idle_left > 0 && !busy) begin
                idle_left--;
            end
            if (!nxt_start && idle_left == 0 && pending_reqs.size() > 0) begin
                nxt_req = pending_reqs[0];
                pending_reqs.delete(0);
                nxt_start = 1'b1;
            end
        end
        cur_req       <= nxt_req;
        start         <= nxt_start;
        i_cmd         <= nxt_req.cmd;
        i_lookup_key  <= nxt_req.key;
        i_write_value <= nxt_req.value;
    end

    always @(posedge i_clk) begin : result_monitor
        t_cache_resp want;
        if (i_rst_n && o_valid) begin
            if (expected_responses.size() == 0) begin
                log_mismatch("unexpected result, hit", 32'(o_hit), '0);
            end else begin
                want = expected_responses[0];
                expected_responses.delete(0);
                if (o_hit !== want.hit)
                    log_mismatch("hit", 32'(o_hit), 32'(want.hit));
                if (o_read_value !== want.read_value)
                    log_mismatch("read_value", o_read_value, want.read_value);
                if (o_evicted !== want.evicted)
                    log_mismatch("evicted", 32'(o_evicted), 32'(want.evicted));
                if (o_evicted_key !== want.evicted_key)
                    log_mismatch("evicted_key", o_evicted_key, want.evicted_key);
            end
            resp_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || run_done || (start && !busy) || o_valid ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_request(input logic cmd, input logic signed [31:0] key,
                                 input logic signed [31:0] value);
        t_cache_req req;
        req.cmd   = cmd;
        req.key   = key;
        req.value = value;
        pending_reqs = {pending_reqs, req};
        issued_count++;
    endtask

    task automatic wait_for_idle();
        do @(negedge i_clk);
        while (accepted_count != issued_count || expected_responses.size() != 0 || busy);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic apb_access(input bit is_write, input logic [ADDR_W-1:0] addr,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_capacity_readback();
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, {REG_CAPACITY, 2'b00}, '0, rd);
        if (rd !== APB_DW'(mdl_capacity))
            log_mismatch("capacity readback", rd, APB_DW'(mdl_capacity));
    endtask

    task automatic program_capacity(input int cap);
        logic [APB_DW-1:0] rd;
        apb_access(1'b1, {REG_CAPACITY, 2'b00}, APB_DW'(cap), rd);
        mdl_capacity = cap & ((1 << CAP_W) - 1);
        check_capacity_readback();
    endtask

    task automatic queue_random_phase(input int count, input int span);
        logic signed [31:0] key;
        logic signed [31:0] value;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 8)
                key = key_pool[$urandom_range(0, span - 1)];
            else
                key = $urandom;
            case ($urandom_range(0, 9))
                0:       value = 32'sh8000_0000;
                1:       value = 32'sh7fff_ffff;
                default: value = $urandom;
            endcase
            queue_request($urandom_range(0, 1) ? CMD_PUT : CMD_GET, key, value);
        end
    endtask

    initial begin : sequencer
        int                caps[10];
        int                span;
        logic [APB_DW-1:0] rd;

        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 32'sh0000_0000;
        key_pool[3] = 32'shffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            mdl_key[i]   = '0;
            mdl_value[i] = '0;
            mdl_valid[i] = 1'b0;
            mdl_rank[i]  = 0;
        end
        mdl_fill     = 0;
        mdl_capacity = int'(CAP_RESET);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_capacity_readback();

        // Directed: miss on an empty store, extreme keys and values, an update
        // in place, then fill all entries and push one past full capacity.
        @(negedge i_clk);
        queue_request(CMD_GET, key_pool[0], 32'sh1111_1111);
        queue_request(CMD_PUT, key_pool[0], 32'sh7fff_ffff);
        queue_request(CMD_PUT, key_pool[1], 32'sh8000_0000);
        queue_request(CMD_PUT, key_pool[2], 32'sh0000_0000);
        queue_request(CMD_PUT, key_pool[3], 32'shffff_ffff);
        queue_request(CMD_GET, key_pool[3], '0);
        queue_request(CMD_GET, key_pool[0], '0);
        queue_request(CMD_GET, key_pool[1], '0);
        queue_request(CMD_GET, key_pool[2], '0);
        queue_request(CMD_PUT, key_pool[1], 32'sh1234_5678);
        queue_request(CMD_GET, key_pool[1], '0);
        for (int i = 4; i < 16; i++)
            queue_request(CMD_PUT, key_pool[i], $urandom);
        queue_request(CMD_PUT, key_pool[16], $urandom);
        queue_request(CMD_GET, key_pool[3], '0);
        wait_for_idle();

        // The register index past the map must leave the capacity untouched.
        apb_access(1'b1, {SPARE_REG, 2'b00}, APB_DW'(3), rd);
        check_capacity_readback();

        // The first setting drops the capacity well below the current fill.
        caps = '{1, 16, 2, 9, 16, 4, 1, 13, 7, 0};
        caps[9] = $urandom_range(1, MAX_ENTRIES);
        for (int p = 0; p < 10; p++) begin
            wait_for_idle();
            program_capacity(caps[p]);
            idling_on = (p != 9);
            span = caps[p] + $urandom_range(1, 6);
            if (span > POOL_SIZE)
                span = POOL_SIZE;
            @(negedge i_clk);
            queue_random_phase(PHASE_ITEMS, span);
        end

        wait_for_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        run_done = 1'b1;
        if (fail_count == 0 && expected_responses.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
